>>> hdl/lspc_pkg.sv
`default_nettype none

package lspc_pkg;

    localparam int MAX_POINTS   = 1024;
    localparam int IDX_W        = 11;
    localparam int PNUM_W       = 10;
    localparam int DIST_W       = 16;
    localparam int START_W      = 23;
    localparam int STEP_ANGLE_W = 20;
    localparam int HALVE_W      = 1;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 23;
    localparam int PROD_W       = 30;
    localparam int ANGLE_W      = 32;
    localparam int Z_W          = 32;
    localparam int GAIN_W       = 30;
    localparam int YINIT_W      = 46;
    localparam int XY_W         = 49;
    localparam int FRAC_W       = 30;
    localparam int POS_W        = 17;
    localparam int OUT_TDATA_W  = 48;

    localparam int CORDIC_STEPS = 16;
    localparam int ITER_W       = 4;

    localparam int START_MIN    = -572958;
    localparam int START_MAX    = 1800000;
    localparam int ANGLE_LOW    = 800000;
    localparam int ANGLE_HIGH   = 1000000;
    localparam int ANGLE_MID    = 900000;
    localparam int INV_GAIN_Q30 = 652032874;
    localparam int OUT_LIMIT    = 65535;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_ANGLE    = 2'd0,
        REG_ANGLE_STEP     = 2'd1,
        REG_POINT_COUNT    = 2'd2,
        REG_HALVE_DISTANCE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              load;
        logic              mul;
        logic              add;
        logic              init;
        logic              rot;
        logic              emit;
        logic [ITER_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic go;
        logic hit;
    } status_t;

    // atan(2^-i) in 1e-4/256 degree units
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [ITER_W-1:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            4'd0:    v = 32'sd115200000;
            4'd1:    v = 32'sd68006531;
            4'd2:    v = 32'sd35932783;
            4'd3:    v = 32'sd18240042;
            4'd4:    v = 32'sd9155416;
            4'd5:    v = 32'sd4582171;
            4'd6:    v = 32'sd2291645;
            4'd7:    v = 32'sd1145892;
            4'd8:    v = 32'sd572955;
            4'd9:    v = 32'sd286479;
            4'd10:   v = 32'sd143239;
            4'd11:   v = 32'sd71620;
            4'd12:   v = 32'sd35810;
            4'd13:   v = 32'sd17905;
            4'd14:   v = 32'sd8952;
            default: v = 32'sd4476;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/lspc_ctrl.sv
`default_nettype none

module lspc_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic             m_tready,
    output logic                  m_tvalid,
    input  wire lspc_pkg::status_t status,
    output lspc_pkg::cmd_t        cmd
);
    import lspc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_INIT,
        ST_ROT,
        ST_EMIT
    } state_t;

    state_t            state_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              m_tvalid_reg;
    logic              out_free;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

    always_comb
    begin
        cmd      = '0;
        cmd.load = (state_reg == ST_IDLE) && s_tvalid;
        cmd.mul  = (state_reg == ST_MUL);
        cmd.add  = (state_reg == ST_ADD);
        cmd.init = (state_reg == ST_INIT);
        cmd.rot  = (state_reg == ST_ROT);
        cmd.emit = (state_reg == ST_EMIT) && out_free;
        cmd.iter = iter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            iter_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                        state_reg <= ST_MUL;
                end
                ST_MUL:
                begin
                    state_reg <= status.go ? ST_ADD : ST_IDLE;
                end
                ST_ADD:
                begin
                    state_reg <= ST_INIT;
                end
                ST_INIT:
                begin
                    iter_reg  <= '0;
                    state_reg <= status.hit ? ST_ROT : ST_IDLE;
                end
                ST_ROT:
                begin
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == ITER_W'(CORDIC_STEPS - 1))
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> hdl/lspc_dp.sv
`default_nettype none

module lspc_dp (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [lspc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lspc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic [lspc_pkg::DIST_W-1:0]          s_tdata,
    input  wire logic                                 s_tuser,
    input  wire lspc_pkg::cmd_t                       cmd,
    output lspc_pkg::status_t                         status,
    output logic [lspc_pkg::OUT_TDATA_W-1:0]          m_tdata
);
    import lspc_pkg::*;

    logic signed [START_W-1:0]      start_angle_reg, start_angle_next;
    logic [STEP_ANGLE_W-1:0]        angle_step_reg, angle_step_next;
    logic [IDX_W-1:0]               point_count_reg, point_count_next;
    logic                           halve_reg, halve_next;
    logic [IDX_W-1:0]               point_index_reg, point_index_next;
    logic                           go_reg, go_next;
    logic [PNUM_W-1:0]              idx_reg, idx_next;
    logic [DIST_W-1:0]              dist_reg, dist_next;
    logic [PROD_W-1:0]              prod_reg, prod_next;
    logic [YINIT_W-1:0]             yinit_reg, yinit_next;
    logic signed [ANGLE_W-1:0]      angle_reg, angle_next;
    logic signed [XY_W-1:0]         x_reg, x_next;
    logic signed [XY_W-1:0]         y_reg, y_next;
    logic signed [Z_W-1:0]          z_reg, z_next;
    logic [OUT_TDATA_W-1:0]         tdata_reg, tdata_next;

    logic [IDX_W-1:0]               idx_cur;
    logic [IDX_W-1:0]               limit;
    logic                           in_range;
    logic                           start_ok;
    logic signed [XY_W-1:0]         xs, ys;
    logic signed [Z_W-1:0]          atan_v;
    logic signed [XY_W-1:0]         x_sum, y_sum;
    logic signed [POS_W-1:0]        x_pos, y_pos;

    function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [XY_W-FRAC_W-1:0] r);
        logic signed [POS_W-1:0] v;
        if (r > (XY_W-FRAC_W)'(OUT_LIMIT))
            v = POS_W'(OUT_LIMIT);
        else if (r < -(XY_W-FRAC_W)'(OUT_LIMIT))
            v = -POS_W'(OUT_LIMIT);
        else
            v = r[POS_W-1:0];
        return v;
    endfunction

    assign m_tdata    = tdata_reg;
    assign status.go  = go_reg;
    assign status.hit = (angle_reg > ANGLE_W'(ANGLE_LOW)) && (angle_reg < ANGLE_W'(ANGLE_HIGH));

    always_comb
    begin
        idx_cur  = s_tuser ? '0 : point_index_reg;
        limit    = (point_count_reg < IDX_W'(MAX_POINTS)) ? point_count_reg : IDX_W'(MAX_POINTS);
        in_range = (idx_cur < limit);
        start_ok = (int'(start_angle_reg) >= START_MIN) && (int'(start_angle_reg) <= START_MAX);
        xs       = x_reg >>> cmd.iter;
        ys       = y_reg >>> cmd.iter;
        atan_v   = atan_lut(cmd.iter);
        x_sum    = x_reg + (XY_W'(1) <<< (FRAC_W - 1));
        y_sum    = y_reg + (XY_W'(1) <<< (FRAC_W - 1));
        x_pos    = clamp_pos(x_sum[XY_W-1:FRAC_W]);
        y_pos    = clamp_pos(y_sum[XY_W-1:FRAC_W]);
    end

    always_comb
    begin
        start_angle_next = start_angle_reg;
        angle_step_next  = angle_step_reg;
        point_count_next = point_count_reg;
        halve_next       = halve_reg;
        point_index_next = point_index_reg;
        go_next          = go_reg;
        idx_next         = idx_reg;
        dist_next        = dist_reg;
        prod_next        = prod_reg;
        yinit_next       = yinit_reg;
        angle_next       = angle_reg;
        x_next           = x_reg;
        y_next           = y_reg;
        z_next           = z_reg;
        tdata_next       = tdata_reg;

        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_START_ANGLE:    start_angle_next = cfg_data[START_W-1:0];
                REG_ANGLE_STEP:     angle_step_next  = cfg_data[STEP_ANGLE_W-1:0];
                REG_POINT_COUNT:    point_count_next = cfg_data[IDX_W-1:0];
                REG_HALVE_DISTANCE: halve_next       = cfg_data[HALVE_W-1];
                default:            halve_next       = halve_reg;
            endcase
        end

        if (cmd.load)
        begin
            point_index_next = in_range ? idx_cur + 1'b1 : idx_cur;
            go_next          = in_range && start_ok;
            idx_next         = idx_cur[PNUM_W-1:0];
            dist_next        = halve_reg ? (s_tdata >> 1) : s_tdata;
        end

        if (cmd.mul)
        begin
            prod_next  = PROD_W'(idx_reg) * PROD_W'(angle_step_reg);
            yinit_next = YINIT_W'(dist_reg) * YINIT_W'(INV_GAIN_Q30);
        end

        if (cmd.add)
            angle_next = ANGLE_W'(start_angle_reg) + ANGLE_W'(prod_reg);

        if (cmd.init)
        begin
            x_next = '0;
            y_next = XY_W'(yinit_reg);
            z_next = (angle_reg - ANGLE_W'(ANGLE_MID)) <<< 8;
        end

        if (cmd.rot)
        begin
            if (!z_reg[Z_W-1])
            begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - atan_v;
            end
            else
            begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + atan_v;
            end
        end

        if (cmd.emit)
            tdata_next = {{(OUT_TDATA_W - PNUM_W - 2*POS_W){1'b0}}, idx_reg, y_pos, x_pos};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_angle_reg <= '0;
            angle_step_reg  <= STEP_ANGLE_W'(5000);
            point_count_reg <= IDX_W'(381);
            halve_reg       <= 1'b0;
            point_index_reg <= '0;
            go_reg          <= 1'b0;
        end
        else
        begin
            start_angle_reg <= start_angle_next;
            angle_step_reg  <= angle_step_next;
            point_count_reg <= point_count_next;
            halve_reg       <= halve_next;
            point_index_reg <= point_index_next;
            go_reg          <= go_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        dist_reg  <= dist_next;
        prod_reg  <= prod_next;
        yinit_reg <= yinit_next;
        angle_reg <= angle_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        tdata_reg <= tdata_next;
    end

endmodule

`default_nettype wire

>>> hdl/lidar_scan_polar_to_cartesian.sv
// Laser scanner polar-to-Cartesian point converter.
// Input stream: one distance sample per word, s_tuser high on the first
// sample of a scan. Output stream: one point per sample whose beam angle
// lies strictly between 80 and 100 degrees; other samples give no word.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 start angle, 1 angle step, 2 point count, 3 halve distance).
// Sequence: a sample past the point count or under an invalid start angle
// frees the input after the MUL state, one outside the window after the MUL,
// ADD and INIT states, and a converted sample passes MUL, ADD, INIT, the
// 16 iterations of the single shared CORDIC rotator and EMIT before the
// result lands in the output register; only then is the next sample taken.
// The output register lets the next sample be taken while a point waits;
// a stalled receiver holds the block only when the next point is ready.
// Reset clears the point index, the output valid flag and loads the
// register defaults (start 0, step 5000, count 381, no halving).
`default_nettype none

module lidar_scan_polar_to_cartesian (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [lspc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [lspc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    input  wire logic [lspc_pkg::DIST_W-1:0]          s_tdata,   // distance
    input  wire logic                                 s_tuser,   // first_of_scan
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    output logic [lspc_pkg::OUT_TDATA_W-1:0]          m_tdata    // x_position, y_position, point_number
);
    import lspc_pkg::*;

    cmd_t    cmd;
    status_t status;

    lspc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    lspc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .status    (status),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken again right after a word");

    a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a conversion in progress");

    a_x_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[16:0] != 17'h10000 && m_tdata[33:17] != 17'h10000))
        else $error("position outside clamp range");
`endif

endmodule

`default_nettype wire

>>> tb/lidar_scan_polar_to_cartesian_tb.sv
`timescale 1ns / 1ps

module lidar_scan_polar_to_cartesian_tb;
    import lspc_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RX_HOLD_CYCLES = 400;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic [PNUM_W-1:0]       num;
    } point_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic [DIST_W-1:0]      s_tdata   = '0;
    logic                   s_tuser   = 1'b0;
    logic                   m_tready  = 1'b0;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [OUT_TDATA_W-1:0]  m_tdata;

    // scanner setup and scan position as the block should hold them
    logic signed [START_W-1:0] start_reg  = '0;
    logic [STEP_ANGLE_W-1:0]   step_reg   = 20'd5000;
    logic [IDX_W-1:0]          count_reg  = 11'd381;
    logic                      halve_reg  = 1'b0;
    logic [IDX_W-1:0]          next_index = '0;

    // atan(2^-i) in 1e-4/256 degree units
    longint atan_units [CORDIC_STEPS] = '{
        115200000, 68006531, 35932783, 18240042, 9155416, 4582171, 2291645, 1145892,
        572955, 286479, 143239, 71620, 35810, 17905, 8952, 4476
    };

    point_t expected_points[$];
    int     error_count   = 0;
    int     quiet_cycles  = 0;
    int     hold_requests = 0;
    int     holds_done    = 0;
    bit     tx_idle_en    = 1'b1;
    bit     rx_idle_en    = 1'b1;

    lidar_scan_polar_to_cartesian uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [POS_W-1:0] round_position(input longint v);
        longint r;
        r = (v + (longint'(1) << 29)) >>> FRAC_W;
        if (r > OUT_LIMIT)
            r = OUT_LIMIT;
        if (r < -OUT_LIMIT)
            r = -OUT_LIMIT;
        return r[POS_W-1:0];
    endfunction

    task automatic convert_sample(input logic [DIST_W-1:0] raw_dist, input logic first,
                                  output bit counted);
        longint   lim;
        longint   start_v;
        longint   angle;
        longint   d;
        longint   x;
        longint   y;
        longint   z;
        longint   xs;
        longint   ys;
        logic [IDX_W-1:0] idx;
        point_t   p;
        int       i;
        counted = 1'b0;
        if (first)
            next_index = '0;
        lim = (count_reg < MAX_POINTS) ? count_reg : MAX_POINTS;
        if (next_index >= lim)
            return;
        counted    = 1'b1;
        idx        = next_index;
        next_index = next_index + 1'b1;
        start_v = start_reg;
        if (start_v < START_MIN || start_v > START_MAX)
            return;
        angle = start_v + longint'(idx) * longint'(step_reg);
        if (!(angle > ANGLE_LOW && angle < ANGLE_HIGH))
            return;
        d = longint'(halve_reg ? (raw_dist >> 1) : raw_dist);
        // start from (d, 0) turned by 90 degrees, rotate by the residual
        x = 0;
        y = d * INV_GAIN_Q30;
        z = (angle - ANGLE_MID) * 256;
        for (i = 0; i < CORDIC_STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_units[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_units[i];
            end
        end
        p.x   = round_position(x);
        p.y   = round_position(y);
        p.num = idx[PNUM_W-1:0];
        expected_points = {expected_points, p};
    endtask

    function automatic logic [DIST_W-1:0] rand_distance();
        case ($urandom_range(15))
            0:       return '0;
            1:       return '1;
            default: return DIST_W'($urandom_range(65535));
        endcase
    endfunction

    task automatic send_word(input logic [DIST_W-1:0] raw_dist, input logic first,
                             output bit counted);
        while (tx_idle_en && $urandom_range(99) < 21)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= raw_dist;
        s_tuser  <= first;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        convert_sample(raw_dist, first, counted);
    endtask

    task automatic send_plain(input logic [DIST_W-1:0] raw_dist, input logic first);
        bit counted;
        send_word(raw_dist, first, counted);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_DATA_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        case (r)
            REG_START_ANGLE:    start_reg = v[START_W-1:0];
            REG_ANGLE_STEP:     step_reg  = v[STEP_ANGLE_W-1:0];
            REG_POINT_COUNT:    count_reg = v[IDX_W-1:0];
            REG_HALVE_DISTANCE: halve_reg = v[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input int start, input int step, input int count, input bit halve);
        settle();
        write_reg(REG_START_ANGLE, start[CFG_DATA_W-1:0]);
        write_reg(REG_ANGLE_STEP, CFG_DATA_W'(step));
        write_reg(REG_POINT_COUNT, CFG_DATA_W'(count));
        write_reg(REG_HALVE_DISTANCE, CFG_DATA_W'(halve));
        cfg_we <= 1'b0;
    endtask

    task automatic run_scans(input int budget, input bit noisy);
        int lim;
        int len;
        int n;
        int used;
        int sent;
        bit counted;
        bit first;
        used = 0;
        sent = 0;
        lim  = (count_reg < MAX_POINTS) ? count_reg : MAX_POINTS;
        while (used < budget && sent < 3 * budget)
        begin
            len = lim;
            if (noisy)
            begin
                case ($urandom_range(7))
                    0:       len = lim + $urandom_range(1, 3);
                    1:       len = $urandom_range(0, lim);
                    default: ;
                endcase
            end
            if (len == 0)
                len = 1;
            for (n = 0; n < len && used < budget; n++)
            begin
                first = (n == 0) || (noisy && $urandom_range(39) == 0);
                send_word(rand_distance(), first, counted);
                used += counted;
                sent++;
            end
        end
    endtask

    task automatic test_window_edges();
        set_config(800000, 100000, 4, 1'b0);
        send_plain(16'd100, 1'b1);
        send_plain(16'hFFFF, 1'b0);
        send_plain(16'd500, 1'b0);
        send_plain(16'd1, 1'b0);
        send_plain(16'd777, 1'b0);
        send_plain(16'd0, 1'b1);
        send_plain(16'd0, 1'b0);
    endtask

    task automatic test_distance_extremes();
        set_config(800001, 199998, 2, 1'b1);
        send_plain(16'hFFFF, 1'b1);
        send_plain(16'hFFFF, 1'b0);
        send_plain(16'd1, 1'b1);
        set_config(800001, 199998, 2, 1'b0);
        send_plain(16'hFFFF, 1'b1);
        send_plain(16'd1, 1'b0);
    endtask

    task automatic test_invalid_start();
        set_config(START_MIN - 1, 700000, 3, 1'b0);
        send_plain(16'd1000, 1'b1);
        send_plain(16'd1000, 1'b0);
        // index moved on under the bad start angle
        set_config(START_MIN, 700000, 3, 1'b0);
        send_plain(16'd2000, 1'b0);
        send_plain(16'd3, 1'b1);
        send_plain(16'd4, 1'b0);
        send_plain(16'd5, 1'b0);
        set_config(START_MAX + 1, 0, 3, 1'b0);
        send_plain(16'd9, 1'b1);
        set_config(-3600000, 1048575, 3, 1'b1);
        send_plain(16'd7, 1'b1);
        set_config(3600000, 0, 2047, 1'b0);
        send_plain(16'd8, 1'b1);
        set_config(START_MAX, 1048575, 2047, 1'b1);
        send_plain(16'd8, 1'b1);
    endtask

    task automatic test_zero_count();
        set_config(900000, 0, 0, 1'b0);
        send_plain(16'd11, 1'b1);
        send_plain(16'd12, 1'b0);
    endtask

    task automatic test_random_scans();
        int phase;
        for (phase = 0; phase < 10; phase++)
        begin
            if (phase == 0 || phase == 3)
                set_config($urandom_range(800001, 999999), 0, $urandom_range(1, 120),
                           1'($urandom_range(1)));
            else if ($urandom_range(3) == 0)
                set_config(int'($urandom_range(7200000)) - 3600000, $urandom_range(1048575),
                           $urandom_range(2047), 1'($urandom_range(1)));
            else
                set_config($urandom_range(700000, 990000), $urandom_range(3000),
                           $urandom_range(1, 120), 1'($urandom_range(1)));
            tx_idle_en = (phase != 5);
            rx_idle_en = (phase != 5);
            // receiver backs up while the sender keeps offering words
            if (phase == 3)
                hold_requests++;
            run_scans(45, 1'b1);
        end
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_long_scan();
        set_config($urandom_range(800001, 850000), $urandom_range(140), 2047,
                   1'($urandom_range(1)));
        run_scans(MAX_POINTS + 2, 1'b0);
    endtask

    initial
    begin : sink
        forever
        begin
            @(posedge clk);
            if (hold_requests != holds_done)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
                m_tready <= !(rx_idle_en && $urandom_range(99) < 21);
        end
    end

    always @(posedge clk)
    begin : monitor
        point_t                  want;
        logic signed [POS_W-1:0] got_x;
        logic signed [POS_W-1:0] got_y;
        logic [PNUM_W-1:0]       got_num;
        if (m_tvalid && m_tready)
        begin
            got_x   = m_tdata[POS_W-1:0];
            got_y   = m_tdata[2*POS_W-1:POS_W];
            got_num = m_tdata[2*POS_W+PNUM_W-1:2*POS_W];
            if (expected_points.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected point: expected none, got x=%0d y=%0d n=%0d",
                         $time, got_x, got_y, got_num);
            end
            else
            begin
                want = expected_points.pop_front();
                if (got_x !== want.x)
                begin
                    error_count++;
                    $display("%0t: x_position expected %0d got %0d", $time, want.x, got_x);
                end
                if (got_y !== want.y)
                begin
                    error_count++;
                    $display("%0t: y_position expected %0d got %0d", $time, want.y, got_y);
                end
                if (got_num !== want.num)
                begin
                    error_count++;
                    $display("%0t: point_number expected %0d got %0d", $time, want.num,
                             got_num);
                end
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
            $display("** lidar_scan_polar_to_cartesian: FAILED **");
            $finish;
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_window_edges();
        test_distance_extremes();
        test_invalid_start();
        test_zero_count();
        test_random_scans();
        test_long_scan();
        settle();
        if (error_count == 0)
            $display("** lidar_scan_polar_to_cartesian: PASSED **");
        else
            $display("** lidar_scan_polar_to_cartesian: FAILED **");
        $finish;
    end

endmodule
